// File: rtl/tns_pkg.sv
// Shared types and constants for the top-N selector.
// Depends on nothing; imported by the selector cell and the top level.
package tns_pkg;

  localparam int KEY_W     = 32;
  localparam int ID_W      = 32;
  localparam int N_LIMIT_W = 5;
  localparam int KEY_CNT_W = 2;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_N_LIMIT     = 2'd0;
  localparam logic [1:0] REG_KEY_COUNT   = 2'd1;
  localparam logic [1:0] REG_PRIMARY_DSC = 2'd2;
  localparam logic [1:0] REG_SECOND_DSC  = 2'd3;

  // Input item kinds
  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // One kept row; primary key sits in the low bits
  typedef struct packed {
    logic        [ID_W-1:0]  row_id;
    logic signed [KEY_W-1:0] secondary_key;
    logic signed [KEY_W-1:0] primary_key;
  } row_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic offer;     // insert the new row this cycle
    logic drain;     // move every row one cell toward the head
    logic two_keys;  // compare the secondary key on a primary tie
    logic p_desc;
    logic s_desc;
  } cell_ctl_t;

endpackage

// File: rtl/top_n_selector.sv
// Top level of the top-N selector: stream ports, APB registers, cell chain control.
// Depends on tns_pkg and tns_cell.

// The block keeps the best n_limit rows (at most CAPACITY) in a chain of
// cells sorted best first, ordered by primary key and, when key_count is two
// or more, by secondary key, each ascending or descending. On an offer beat
// (in_tuser = 0) every cell compares the new row with its own in parallel,
// and the row drops into place while worse rows move one cell down; a row
// that ties with a kept one goes after it. Offers stream at one beat per
// cycle while no drain is under way. A finish beat (in_tuser = 1) starts a
// drain: the kept rows leave from the head cell at one beat per cycle while
// the receiver is ready, best first, with out_tlast on the final one, and the
// store is empty afterward. While draining the input is stalled, so a finish
// occupies the block for the finish beat plus one beat per kept row, plus any
// stall on the output side; an empty store emits nothing. The user must write
// configuration only while the block is idle; the block does not enforce it.
module top_n_selector
  import tns_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: primary_key[31:0], secondary_key[63:32], row_id[95:64]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,
  // in_tuser: operation (0 offer, 1 finish)
  input  logic              in_tuser,
  // out_tdata: out_primary_key[31:0], out_secondary_key[63:32], out_row_id[95:64]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > N_LIMIT_W) ? CW : N_LIMIT_W;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [N_LIMIT_W-1:0]   n_limit_r;
  logic [KEY_CNT_W-1:0]   key_count_r;
  logic                   p_desc_r, s_desc_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;

  logic                   cfg_wr;
  logic [1:0]             cfg_idx;
  logic                   in_acc, out_acc, offer, finish;
  logic [MW-1:0]          lim_wide, cap_wide;
  logic [CW-1:0]          limit_eff, count_eff;
  logic [CAPACITY-1:0]    b_vec, occ_vec, lim_mask;
  logic                   ins_ok;
  cell_ctl_t              ctl;
  row_t                   row_in;
  row_t                   rows [CAPACITY];

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_limit_r   <= N_LIMIT_W'(16);
      key_count_r <= KEY_CNT_W'(1);
      p_desc_r    <= 1'b0;
      s_desc_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_N_LIMIT:     n_limit_r   <= cfg_pwdata[N_LIMIT_W-1:0];
        REG_KEY_COUNT:   key_count_r <= cfg_pwdata[KEY_CNT_W-1:0];
        REG_PRIMARY_DSC: p_desc_r    <= cfg_pwdata[0];
        REG_SECOND_DSC:  s_desc_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_N_LIMIT:     cfg_prdata = CFG_DW'(n_limit_r);
      REG_KEY_COUNT:   cfg_prdata = CFG_DW'(key_count_r);
      REG_PRIMARY_DSC: cfg_prdata = CFG_DW'(p_desc_r);
      REG_SECOND_DSC:  cfg_prdata = CFG_DW'(s_desc_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------- beat decode ----------------
  assign in_tready = (state_r == ST_COLLECT);
  assign in_acc    = in_tvalid && in_tready;
  assign offer     = in_acc && (in_tuser == OP_OFFER);
  assign finish    = in_acc && (in_tuser == OP_FINISH);
  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_acc   = out_tvalid && out_tready;

  assign row_in.primary_key   = in_tdata[31:0];
  assign row_in.secondary_key = in_tdata[63:32];
  assign row_in.row_id        = in_tdata[95:64];

  // Saturate the limit to the chain length, trim the count to the limit
  assign lim_wide  = MW'(n_limit_r);
  assign cap_wide  = MW'(CAPACITY);
  assign limit_eff = (lim_wide > cap_wide) ? CW'(cap_wide) : CW'(lim_wide);
  assign count_eff = (count_r > limit_eff) ? limit_eff : count_r;

  always_comb begin
    ctl.offer    = offer;
    ctl.drain    = out_acc;
    ctl.two_keys = key_count_r[1];
    ctl.p_desc   = p_desc_r;
    ctl.s_desc   = s_desc_r;
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic b_prev;
    row_t row_prev, row_next;

    assign occ_vec[i]  = IDX < count_eff;
    assign lim_mask[i] = IDX < limit_eff;

    if (i == 0) begin : g_head
      assign b_prev   = 1'b0;
      assign row_prev = row_in;
    end else begin : g_body
      assign b_prev   = b_vec[i-1];
      assign row_prev = rows[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign row_next = rows[i];
    end else begin : g_mid
      assign row_next = rows[i+1];
    end

    tns_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (occ_vec[i]),
      .b_prev   (b_prev),
      .row_new  (row_in),
      .row_prev (row_prev),
      .row_next (row_next),
      .b_out    (b_vec[i]),
      .row      (rows[i])
    );
  end

  // The new row is kept if its slot lies inside the limit
  assign ins_ok = |(b_vec & lim_mask);

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    case (state_r)
      ST_COLLECT: begin
        if (offer) begin
          if (ins_ok && (count_eff != limit_eff)) begin
            count_nxt = count_eff + CW'(1);
          end else begin
            count_nxt = count_eff;
          end
        end else if (finish) begin
          count_nxt = '0;
          if (count_r != '0) begin
            rem_nxt   = count_r;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          rem_nxt = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Head cell drives the output beat
  assign out_tdata = {rows[0].row_id, rows[0].secondary_key, rows[0].primary_key};
  assign out_tlast = (rem_r == CW'(1));

endmodule

// File: rtl/tns_cell.sv
// One cell of the sorted row chain: holds a row, compares it with the offered row.
// Depends on tns_pkg.
module tns_cell
  import tns_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,  // this cell holds a kept row
  input  logic      b_prev,    // the cell ahead takes part in the insert
  input  row_t      row_new,
  input  row_t      row_prev,
  input  row_t      row_next,
  output logic      b_out,     // new row goes here or ahead of here
  output row_t      row
);

  row_t row_r, row_nxt;
  logic p_better, s_better, better;

  always_comb begin
    if (ctl.p_desc) begin
      p_better = row_new.primary_key > row_r.primary_key;
    end else begin
      p_better = row_new.primary_key < row_r.primary_key;
    end
    if (ctl.s_desc) begin
      s_better = row_new.secondary_key > row_r.secondary_key;
    end else begin
      s_better = row_new.secondary_key < row_r.secondary_key;
    end
    if (row_new.primary_key != row_r.primary_key) begin
      better = p_better;
    end else if (ctl.two_keys && (row_new.secondary_key != row_r.secondary_key)) begin
      better = s_better;
    end else begin
      better = 1'b0;
    end
  end

  assign b_out = !occupied || better;

  always_comb begin
    row_nxt = row_r;
    if (ctl.drain) begin
      row_nxt = row_next;
    end else if (ctl.offer && b_out) begin
      // first cell that takes the new row loads it, the rest shift down
      row_nxt = b_prev ? row_prev : row_new;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row = row_r;

endmodule

// File: verif/top_n_selector_test.sv
// Self-checking bench for the top-N selector: streams rows and finish beats,
// tracks the kept store locally and checks each drained row as it leaves.
// Depends on tns_pkg and the top_n_selector RTL.
module top_n_selector_test;
  import tns_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int IDLE_LIMIT = 2000;  // cycles without any beat or register access
  localparam int SETTLE_CYC = 10;    // margin after the queues empty
  localparam int HOLD_CYC   = 150;   // long receiver hold-off for the backpressure check

  // One beat on the input stream
  typedef struct {
    logic op;
    row_t row;
  } scan_item_t;

  // One drained row as it should appear on the output stream
  typedef struct {
    row_t row;
    logic last;
  } emit_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [95:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Local copy of the ordering registers and the kept store
  logic [N_LIMIT_W-1:0] lim_reg = 5'd16;
  logic [KEY_CNT_W-1:0] keys_reg = 2'd1;
  logic                 pdesc_reg = 1'b0;
  logic                 sdesc_reg = 1'b0;
  row_t                 kept_rows [CAPACITY];
  int                   kept_total = 0;

  scan_item_t scan_queue[$];     // rows waiting to be driven
  emit_t      emit_due[$];       // drained rows still to arrive
  scan_item_t row_on_bus;
  int         rows_in_flight = 0;
  int         errors = 0;
  int         send_wait = 0;
  int         send_calm = 0;
  int         recv_wait = 0;
  int         recv_calm = 0;
  int         hold_left = 0;
  bit         pressure_armed = 1'b0;
  int         idle_cycles = 0;

  top_n_selector #(.CAPACITY(CAPACITY)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // primary_key, secondary_key, row_id (low to high)
    .in_tuser    (in_tuser),     // operation
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // out_primary_key, out_secondary_key, out_row_id
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Order of one signed key: -1 when a sorts ahead of b, 1 when behind, 0 on a tie
  function automatic int key_rank(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b,
                                  logic desc);
    int r;
    r = 0;
    if (a < b) r = -1;
    else if (a > b) r = 1;
    return desc ? -r : r;
  endfunction

  // True only when row a sorts strictly ahead of row b; a tie keeps the older row first
  function automatic bit outranks(row_t a, row_t b);
    int r;
    r = key_rank(a.primary_key, b.primary_key, pdesc_reg);
    if (r != 0) return r < 0;
    // key_count 0 acts as one key, 3 as two
    if (keys_reg >= 2) begin
      r = key_rank(a.secondary_key, b.secondary_key, sdesc_reg);
      if (r != 0) return r < 0;
    end
    return 1'b0;
  endfunction

  // Apply one accepted beat to the local store; a finish queues the drained rows
  function automatic void rank_row(scan_item_t it);
    int cap_lim;
    int pos;
    int n;
    emit_t e;
    cap_lim = (lim_reg > CAPACITY) ? CAPACITY : int'(lim_reg);
    if (it.op == OP_OFFER) begin
      // A limit lowered since the last offer trims the worst rows first
      if (kept_total > cap_lim) kept_total = cap_lim;
      pos = 0;
      while (pos < kept_total && !outranks(it.row, kept_rows[pos])) pos++;
      if (pos < cap_lim) begin
        n = (kept_total + 1 > cap_lim) ? cap_lim : kept_total + 1;
        for (int i = n - 1; i > pos; i--) kept_rows[i] = kept_rows[i-1];
        kept_rows[pos] = it.row;
        kept_total = n;
      end
    end else begin
      // Drain everything kept, even past a lowered limit; empty store sends nothing
      for (int i = 0; i < kept_total; i++) begin
        e.row = kept_rows[i];
        e.last = (i == kept_total - 1);
        emit_due.push_back(e);
      end
      kept_total = 0;
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none at all
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 30);
  endfunction

  // Keys lean toward a narrow band so ties are common, with extremes mixed in
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 6) - 3;
      4:          return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      5:          return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: hold a beat until taken, then advance to the next row after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rank_row(row_on_bus);
        rows_in_flight--;
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (scan_queue.size() != 0) begin
          row_on_bus = scan_queue.pop_front();
          in_tdata  <= row_on_bus.row;
          in_tuser  <= row_on_bus.op;
          in_tvalid <= 1'b1;
          send_wait = gap_len(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each drained beat against the oldest pending row, then
  // pick the next ready level. Once armed, the first drained beat seen
  // triggers a long hold-off so the chain stays full and the input stalls.
  always @(posedge clk) begin
    row_t  got;
    emit_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = row_t'(out_tdata);
        if (emit_due.size() == 0) begin
          $display("%0t: unexpected row, expected none, actual p=%h s=%h id=%h last=%b",
                   $time, got.primary_key, got.secondary_key, got.row_id, out_tlast);
          errors++;
        end else begin
          want = emit_due.pop_front();
          compare_field("primary_key", want.row.primary_key, got.primary_key);
          compare_field("secondary_key", want.row.secondary_key, got.secondary_key);
          compare_field("row_id", want.row.row_id, got.row_id);
          compare_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (pressure_armed && out_tvalid) begin
        pressure_armed = 1'b0;
        hold_left = HOLD_CYC;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_wait = gap_len(recv_calm);
      end
    end
  end

  // Watchdog: any beat or register access restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("top_n_selector regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_row(input logic op, input logic [31:0] p, input logic [31:0] s,
                           input logic [31:0] id);
    scan_item_t it;
    it.op = op;
    it.row.primary_key = p;
    it.row.secondary_key = s;
    it.row.row_id = id;
    rows_in_flight++;
    scan_queue.push_back(it);
  endtask

  // Wait until every queued row is taken and every drained row has arrived
  task automatic settle();
    while (rows_in_flight != 0 || emit_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup, then access; the register lands on the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_N_LIMIT:     lim_reg   = value[N_LIMIT_W-1:0];
      REG_KEY_COUNT:   keys_reg  = value[KEY_CNT_W-1:0];
      REG_PRIMARY_DSC: pdesc_reg = value[0];
      REG_SECOND_DSC:  sdesc_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_order(input int lim, input int keys, input bit pd, input bit sd);
    write_reg(REG_N_LIMIT, lim);
    write_reg(REG_KEY_COUNT, keys);
    write_reg(REG_PRIMARY_DSC, CFG_DW'(pd));
    write_reg(REG_SECOND_DSC, CFG_DW'(sd));
  endtask

  // Runs of random offers closed by a finish; a few runs overflow the store,
  // a few are empty. Without close_store the last rows stay kept.
  task automatic queue_random_runs(input int budget, input bit close_store);
    int queued;
    int run;
    int r;
    queued = 0;
    while (queued < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) run = $urandom_range(1, 18);
      else if (r < 85) run = $urandom_range(17, 40);
      else run = $urandom_range(0, 2);
      repeat (run) queue_row(OP_OFFER, pick_key(), pick_key(), $urandom);
      queued += run;
      if (queued < budget || close_store) begin
        queue_row(OP_FINISH, $urandom, $urandom, $urandom);
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset order: sixteen rows, primary key ascending only.
    // Finish on an empty store, then extremes and a primary tie (stays in arrival order).
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    queue_row(OP_OFFER, 32'd5, 32'd1, 32'd1);
    queue_row(OP_OFFER, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_row(OP_OFFER, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    queue_row(OP_OFFER, 32'd5, -32'sd9, 32'd2);
    queue_row(OP_OFFER, -32'sd1, 32'd0, 32'd3);
    queue_row(OP_OFFER, 32'd0, -32'sd1, 32'd4);
    queue_row(OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Three rows, two keys, primary descending: a tie with the worst is dropped,
    // a worse row is dropped, a better one pushes the worst out.
    set_order(3, 2, 1'b1, 1'b0);
    queue_row(OP_OFFER, 32'd4, 32'd2, 32'd10);
    queue_row(OP_OFFER, 32'd4, 32'd1, 32'd11);
    queue_row(OP_OFFER, 32'd9, 32'd0, 32'd12);
    queue_row(OP_OFFER, 32'd4, 32'd2, 32'd13);
    queue_row(OP_OFFER, 32'd4, 32'd3, 32'd14);
    queue_row(OP_OFFER, 32'd4, 32'd0, 32'd15);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Limit above capacity saturates; key count three compares two keys.
    set_order(20, 3, 1'b0, 1'b1);
    queue_row(OP_OFFER, 32'd1, 32'd5, 32'd20);
    queue_row(OP_OFFER, 32'd1, 32'd7, 32'd21);
    queue_row(OP_OFFER, 32'd1, 32'd5, 32'd22);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Limit zero drops every offer and the finish sends nothing.
    write_reg(REG_N_LIMIT, 0);
    queue_row(OP_OFFER, 32'd3, 32'd3, 32'd30);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Limit lowered under kept rows: a finish drains them all; key count zero
    // acts as primary only.
    set_order(16, 0, 1'b1, 1'b1);
    repeat (4) queue_row(OP_OFFER, pick_key(), pick_key(), $urandom);
    settle();
    write_reg(REG_N_LIMIT, 2);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Limit lowered under kept rows: the next offer trims the store first.
    write_reg(REG_N_LIMIT, 16);
    repeat (5) queue_row(OP_OFFER, pick_key(), pick_key(), $urandom);
    settle();
    write_reg(REG_N_LIMIT, 3);
    queue_row(OP_OFFER, pick_key(), pick_key(), $urandom);
    queue_row(OP_FINISH, 32'h0, 32'h0, 32'h0);
    settle();

    // Random phases. The first one opens with a full store and a long
    // receiver hold-off while more offers wait behind the drain.
    set_order(16, 2, 1'b0, 1'b1);
    pressure_armed = 1'b1;
    repeat (20) queue_row(OP_OFFER, pick_key(), pick_key(), $urandom);
    queue_row(OP_FINISH, $urandom, $urandom, $urandom);
    queue_random_runs(30, 1'b1);
    settle();

    set_order(1, 3, 1'b1, 1'b0);
    queue_random_runs(40, 1'b1);
    settle();

    set_order(31, 0, 1'b1, 1'b1);
    queue_random_runs(50, 1'b1);
    settle();

    set_order($urandom_range(0, 31), $urandom_range(0, 3), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    queue_random_runs(40, 1'b1);
    settle();

    // Leave rows kept across the next write so the lowered limit trims them
    set_order(7, 2, 1'b0, 1'b0);
    queue_random_runs(40, 1'b0);
    settle();

    set_order(2, 1, 1'b0, 1'b1);
    queue_random_runs(40, 1'b1);
    settle();
    repeat (SETTLE_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("top_n_selector regression: pass");
    end else begin
      $display("top_n_selector regression: fail");
    end
    $finish;
  end

endmodule
